// ===== design/trial_division_factorizer_unit_macros.svh =====
// assertion macros for the factorizer rtl
// no dependencies; included by trial_division_factorizer_unit, the module that carries concurrent checks
`ifndef TRIAL_DIVISION_FACTORIZER_UNIT_MACROS_SVH
`define TRIAL_DIVISION_FACTORIZER_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define TDF_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tdf check failed");

// next-cycle implication, disabled during reset
`define TDF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tdf check failed");

`endif

// ===== design/tdf_pkg.sv =====
// types, constants and microcode rom of the trial division factorizer
// no dependencies; used by the top level through scoped names
package tdf_pkg;

   // result cap per transaction
   localparam int MAX_RESULTS = 30;
   localparam int COUNT_BITS  = $clog2(MAX_RESULTS + 1);
   localparam int UPC_BITS    = 4;

   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [UPC_BITS-1:0]   upc_type;

   // datapath operations
   typedef enum logic [2:0] {
      OP_NOP,
      OP_LOAD,
      OP_EMIT_NONE,
      OP_SQUARE,
      OP_DIV_START,
      OP_EMIT_FACTOR,
      OP_EMIT_REM,
      OP_NEXT_DIV
   } op_type;

   // branch conditions
   typedef enum logic [2:0] {
      CND_NEVER,
      CND_ALWAYS,
      CND_NO_START,
      CND_NOT_SMALL,
      CND_CAP,
      CND_SQ_GT,
      CND_DIV_BUSY,
      CND_REM_NZ
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      upc_type  target;
   } ucode_type;

   // program step addresses
   localparam upc_type STEP_IDLE      = 4'd0;
   localparam upc_type STEP_TEST_SMALL = 4'd1;
   localparam upc_type STEP_EMIT_NONE = 4'd2;
   localparam upc_type STEP_CHK_CAP   = 4'd3;
   localparam upc_type STEP_SQUARE    = 4'd4;
   localparam upc_type STEP_TEST_SQ   = 4'd5;
   localparam upc_type STEP_DIV_START = 4'd6;
   localparam upc_type STEP_DIV_WAIT  = 4'd7;
   localparam upc_type STEP_TEST_MOD  = 4'd8;
   localparam upc_type STEP_EMIT_FACT = 4'd9;
   localparam upc_type STEP_TAIL      = 4'd10;
   localparam upc_type STEP_NEXT_DIV  = 4'd11;

   // control store
   function automatic ucode_type ucode_rom(input upc_type upc);
      ucode_type w;
      w = '{op: OP_NOP, cond: CND_ALWAYS, target: STEP_IDLE};
      case (upc)
         STEP_IDLE:       w = '{op: OP_LOAD,        cond: CND_NO_START,  target: STEP_IDLE};
         STEP_TEST_SMALL: w = '{op: OP_NOP,         cond: CND_NOT_SMALL, target: STEP_CHK_CAP};
         STEP_EMIT_NONE:  w = '{op: OP_EMIT_NONE,   cond: CND_ALWAYS,    target: STEP_IDLE};
         STEP_CHK_CAP:    w = '{op: OP_NOP,         cond: CND_CAP,       target: STEP_IDLE};
         STEP_SQUARE:     w = '{op: OP_SQUARE,      cond: CND_NEVER,     target: STEP_IDLE};
         STEP_TEST_SQ:    w = '{op: OP_NOP,         cond: CND_SQ_GT,     target: STEP_TAIL};
         STEP_DIV_START:  w = '{op: OP_DIV_START,   cond: CND_NEVER,     target: STEP_IDLE};
         STEP_DIV_WAIT:   w = '{op: OP_NOP,         cond: CND_DIV_BUSY,  target: STEP_DIV_WAIT};
         STEP_TEST_MOD:   w = '{op: OP_NOP,         cond: CND_REM_NZ,    target: STEP_NEXT_DIV};
         STEP_EMIT_FACT:  w = '{op: OP_EMIT_FACTOR, cond: CND_ALWAYS,    target: STEP_CHK_CAP};
         STEP_TAIL:       w = '{op: OP_EMIT_REM,    cond: CND_ALWAYS,    target: STEP_IDLE};
         STEP_NEXT_DIV:   w = '{op: OP_NEXT_DIV,    cond: CND_ALWAYS,    target: STEP_CHK_CAP};
         default:         w = '{op: OP_NOP,         cond: CND_ALWAYS,    target: STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

// ===== design/tdf_divider.sv =====
// bit-serial restoring divider, one quotient bit per cycle
// no dependencies; instantiated by trial_division_factorizer_unit
module tdf_divider #(
   parameter int VALUE_BITS = 31,
   parameter int DIV_BITS   = 17
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [VALUE_BITS-1:0] dividend,
   input  logic [DIV_BITS-1:0]   divisor,
   output logic                  busy,
   output logic [VALUE_BITS-1:0] quotient,
   output logic [DIV_BITS-1:0]   remainder
);

   localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

   logic                  busy_ff, busy_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0] dvd_ff, dvd_in;
   logic [DIV_BITS-1:0]   dvs_ff, dvs_in;
   logic [DIV_BITS-1:0]   rem_ff, rem_in;
   logic [DIV_BITS:0]     part;
   logic [DIV_BITS+1:0]   diff;

   // one restoring step: shift in the next dividend bit and trial subtract
   assign part = {rem_ff, dvd_ff[VALUE_BITS-1]};
   assign diff = {1'b0, part} - {2'b00, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(VALUE_BITS);
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
         end
         if (!diff[DIV_BITS+1]) begin
            rem_in = diff[DIV_BITS-1:0];
            dvd_in = {dvd_ff[VALUE_BITS-2:0], 1'b1};
         end else begin
            rem_in = part[DIV_BITS-1:0];
            dvd_in = {dvd_ff[VALUE_BITS-2:0], 1'b0};
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   // operand and partial remainder registers
   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign busy      = busy_ff;
   assign quotient  = dvd_ff;
   assign remainder = rem_ff;

endmodule

// ===== design/trial_division_factorizer_unit.sv =====
// sequence: an input below 2 is tested and answered with a single no-factors result; any other
// input tries divisor 2 and then odd divisors from 3, each try a cap check, a square,
// a compare against the remaining cofactor and one serial divide, until the square exceeds the
// cofactor or the cap is hit; worst case about 23170 odd divisors at VALUE_BITS = 31.
// throughput: one transaction at a time; busy holds until the last result is registered.
// results appear one cycle on rsp_valid each and cannot be stalled.
// reset (synchronous, active high) returns the sequencer to idle with no result pending.
//
// top level: microcoded sequencer, divisor/square datapath and result register
// depends on tdf_pkg, tdf_divider and trial_division_factorizer_unit_macros.svh
`include "trial_division_factorizer_unit_macros.svh"

module trial_division_factorizer_unit #(
   parameter int VALUE_BITS = 31
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                  rsp_valid,
   output logic [VALUE_BITS-1:0] rsp_factor,
   output logic                  rsp_no_factors,
   output logic                  rsp_last
);

   localparam int DIV_BITS = VALUE_BITS / 2 + 2;
   localparam int SQ_BITS  = 2 * DIV_BITS;

   tdf_pkg::upc_type      upc_ff, upc_in;
   tdf_pkg::ucode_type    uword;
   tdf_pkg::count_type    count_ff, count_in;
   logic [VALUE_BITS-1:0] rem_ff, rem_in;
   logic [DIV_BITS-1:0]   dvs_ff, dvs_in;
   logic [SQ_BITS-1:0]    sq_ff, sq_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0] rsp_factor_ff, rsp_factor_in;
   logic                  rsp_none_ff, rsp_none_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  cond_true;
   logic                  div_start;
   logic                  div_busy;
   logic [VALUE_BITS-1:0] div_quot;
   logic [DIV_BITS-1:0]   div_rem;
   logic                  rem_gt1;
   logic                  cap_next;

   // divider unit
   tdf_divider #(
      .VALUE_BITS(VALUE_BITS),
      .DIV_BITS  (DIV_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (rem_ff),
      .divisor  (dvs_ff),
      .busy     (div_busy),
      .quotient (div_quot),
      .remainder(div_rem)
   );

   // control word fetch
   assign uword     = tdf_pkg::ucode_rom(upc_ff);
   assign busy      = (upc_ff != tdf_pkg::STEP_IDLE);
   assign div_start = (uword.op == tdf_pkg::OP_DIV_START);
   assign rem_gt1   = |rem_ff[VALUE_BITS-1:1];
   assign cap_next  = (count_ff == tdf_pkg::count_type'(tdf_pkg::MAX_RESULTS - 1));

   // branch condition select
   always_comb begin
      case (uword.cond)
         tdf_pkg::CND_NEVER:     cond_true = 1'b0;
         tdf_pkg::CND_ALWAYS:    cond_true = 1'b1;
         tdf_pkg::CND_NO_START:  cond_true = !start;
         tdf_pkg::CND_NOT_SMALL: cond_true = rem_gt1;
         tdf_pkg::CND_CAP:
            cond_true = (count_ff == tdf_pkg::count_type'(tdf_pkg::MAX_RESULTS));
         tdf_pkg::CND_SQ_GT:     cond_true = (sq_ff > SQ_BITS'(rem_ff));
         tdf_pkg::CND_DIV_BUSY:  cond_true = div_busy;
         tdf_pkg::CND_REM_NZ:    cond_true = (div_rem != '0);
         default:                cond_true = 1'b0;
      endcase
   end

   // step counter
   assign upc_in = cond_true ? uword.target : upc_ff + tdf_pkg::upc_type'(1);

   // datapath driven by the control word
   always_comb begin
      count_in      = count_ff;
      rem_in        = rem_ff;
      dvs_in        = dvs_ff;
      sq_in         = sq_ff;
      rsp_valid_in  = 1'b0;
      rsp_factor_in = rsp_factor_ff;
      rsp_none_in   = rsp_none_ff;
      rsp_last_in   = rsp_last_ff;
      case (uword.op)
         tdf_pkg::OP_LOAD: begin
            rem_in   = req_value;
            dvs_in   = DIV_BITS'(2);
            count_in = '0;
         end
         tdf_pkg::OP_EMIT_NONE: begin
            rsp_valid_in  = 1'b1;
            rsp_factor_in = '0;
            rsp_none_in   = 1'b1;
            rsp_last_in   = 1'b1;
         end
         tdf_pkg::OP_SQUARE: begin
            sq_in = dvs_ff * dvs_ff;
         end
         tdf_pkg::OP_EMIT_FACTOR: begin
            rsp_valid_in  = 1'b1;
            rsp_factor_in = VALUE_BITS'(dvs_ff);
            rsp_none_in   = 1'b0;
            // last when the cap is hit or nothing is left to split
            rsp_last_in   = cap_next || (div_quot == VALUE_BITS'(1));
            rem_in        = div_quot;
            count_in      = count_ff + tdf_pkg::count_type'(1);
         end
         tdf_pkg::OP_EMIT_REM: begin
            // leftover cofactor above one is prime
            rsp_valid_in  = rem_gt1;
            rsp_factor_in = rem_ff;
            rsp_none_in   = 1'b0;
            rsp_last_in   = 1'b1;
            if (rem_gt1) begin
               rem_in   = VALUE_BITS'(1);
               count_in = count_ff + tdf_pkg::count_type'(1);
            end
         end
         tdf_pkg::OP_NEXT_DIV: begin
            dvs_in = (dvs_ff == DIV_BITS'(2)) ? DIV_BITS'(3) : dvs_ff + DIV_BITS'(2);
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= tdf_pkg::STEP_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         upc_ff       <= upc_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rem_ff        <= rem_in;
      dvs_ff        <= dvs_in;
      sq_ff         <= sq_in;
      rsp_factor_ff <= rsp_factor_in;
      rsp_none_ff   <= rsp_none_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_factor     = rsp_factor_ff;
   assign rsp_no_factors = rsp_none_ff;
   assign rsp_last       = rsp_last_ff;

   // checks
   `TDF_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `TDF_ASSERT_IMPLIES(a_none_last, clock, reset, rsp_valid && rsp_no_factors,
      rsp_last && (rsp_factor == '0))
   `TDF_ASSERT_IMPLIES(a_div_wait, clock, reset, div_busy, upc_ff == tdf_pkg::STEP_DIV_WAIT)
   `TDF_ASSERT_IMPLIES(a_count_cap, clock, reset, 1'b1,
      count_ff <= tdf_pkg::count_type'(tdf_pkg::MAX_RESULTS))

endmodule
